// ----- src/sortable_fifo_queue_top_defines.svh -----
// Assertion macros for the sortable FIFO queue.
// Used by sortable_fifo_queue_top; needs clk and rst_n in scope.
`ifndef SORTABLE_FIFO_QUEUE_TOP_DEFINES_SVH
`define SORTABLE_FIFO_QUEUE_TOP_DEFINES_SVH

// hold: antecedent implies consequent in the same cycle
`define SFQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// hold: antecedent implies consequent in the next cycle
`define SFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sfq_pkg.sv -----
// Shared types, constants and helpers for the sortable FIFO queue.
// No dependencies; used by sfq_store and sortable_fifo_queue_top.
`default_nettype none

package sfq_pkg;

    localparam int DEPTH     = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_SORT = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ_RD,
        S_SORT_LD,
        S_SORT_AI,
        S_SORT_RDJ,
        S_SORT_CMP,
        S_SORT_WI,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]         raddr;
    } mem_req_t;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] lg);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, lg};
        if (sum >= (CNT_W + 1)'(DEPTH))
            sum = sum - (CNT_W + 1)'(DEPTH);
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/sfq_store.sv -----
// Ring storage of the sortable FIFO queue: one write port, one registered read port.
// Depends on sfq_pkg.
`default_nettype none

module sfq_store (
    input  wire logic                             clk,
    input  wire sfq_pkg::mem_req_t                req,
    output logic signed [sfq_pkg::DATA_W-1:0]     rdata
);

    logic signed [sfq_pkg::DATA_W-1:0] mem [sfq_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ----- src/sortable_fifo_queue_top.sv -----
// Sortable FIFO queue: a 16-entry ring of signed 32-bit values that takes one operation per
// input transfer (enqueue, dequeue, sort ascending) and returns one result transfer for each.
// Enqueue executes and returns its result; dequeue also reads the store. Sort walks an
// exchange sort through the ring store, which has one write port and one registered read
// port: each outer position loads its entry, each compare-exchange reads and compares one
// later entry, and the smallest value is written back to the outer position. Input is not
// ready while an operation runs; a finished result waits in an output register while the
// next one is taken.
// Depends on sfq_pkg, sfq_store and sortable_fifo_queue_top_defines.svh.
`default_nettype none
`include "sortable_fifo_queue_top_defines.svh"

module sortable_fifo_queue_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [sfq_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [31:0] value
    input  wire logic [sfq_pkg::OP_W-1:0]          s_axis_tuser,  // [1:0] opcode
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [sfq_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // [31:0] popped_value,
                                                                  // [36:32] entry_count
    output logic [sfq_pkg::STAT_W-1:0]             m_axis_tuser   // [1:0] status
);

    sfq_pkg::state_t state_reg, state_next;

    logic [sfq_pkg::OP_W-1:0]          op_reg, op_next;
    logic signed [sfq_pkg::DATA_W-1:0] value_reg, value_next;
    logic [sfq_pkg::IDX_W-1:0]         head_reg, head_next;
    logic [sfq_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [sfq_pkg::CNT_W-1:0]         i_reg, i_next;
    logic [sfq_pkg::CNT_W-1:0]         j_reg, j_next;
    logic signed [sfq_pkg::DATA_W-1:0] a_reg, a_next;
    logic signed [sfq_pkg::DATA_W-1:0] popped_reg, popped_next;
    logic [sfq_pkg::STAT_W-1:0]        status_reg, status_next;
    logic                              m_valid_reg, m_valid_next;
    logic signed [sfq_pkg::DATA_W-1:0] m_popped_reg, m_popped_next;
    logic [sfq_pkg::STAT_W-1:0]        m_status_reg, m_status_next;
    logic [sfq_pkg::CNT_W-1:0]         m_count_reg, m_count_next;

    sfq_pkg::mem_req_t                 mem_req;
    logic signed [sfq_pkg::DATA_W-1:0] rdata;

    logic in_xfer;
    logic out_free;
    logic full;
    logic empty;
    logic j_more;
    logic i_more;
    logic swap;

    sfq_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign full     = (count_reg >= sfq_pkg::CNT_W'(sfq_pkg::DEPTH));
    assign empty    = (count_reg == '0);
    assign j_more   = ({1'b0, j_reg} + 1'b1) < {1'b0, count_reg};
    assign i_more   = ({1'b0, i_reg} + 2'd2) < {1'b0, count_reg};
    assign swap     = (a_reg >= rdata);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfq_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = sfq_pkg::S_EXEC;
            end
            sfq_pkg::S_EXEC:
            begin
                case (op_reg)
                    sfq_pkg::OP_DEQ:  state_next = empty ? sfq_pkg::S_OUT : sfq_pkg::S_DEQ_RD;
                    sfq_pkg::OP_SORT:
                    begin
                        if (count_reg < sfq_pkg::CNT_W'(2))
                            state_next = sfq_pkg::S_OUT;
                        else
                            state_next = sfq_pkg::S_SORT_LD;
                    end
                    default:          state_next = sfq_pkg::S_OUT;
                endcase
            end
            sfq_pkg::S_DEQ_RD:   state_next = sfq_pkg::S_OUT;
            sfq_pkg::S_SORT_LD:  state_next = sfq_pkg::S_SORT_AI;
            sfq_pkg::S_SORT_AI:  state_next = sfq_pkg::S_SORT_CMP;
            sfq_pkg::S_SORT_RDJ: state_next = sfq_pkg::S_SORT_CMP;
            sfq_pkg::S_SORT_CMP: state_next = j_more ? sfq_pkg::S_SORT_RDJ : sfq_pkg::S_SORT_WI;
            sfq_pkg::S_SORT_WI:  state_next = i_more ? sfq_pkg::S_SORT_LD : sfq_pkg::S_OUT;
            sfq_pkg::S_OUT:
            begin
                if (out_free)
                    state_next = sfq_pkg::S_IDLE;
            end
            default:             state_next = sfq_pkg::S_IDLE;
        endcase
    end

    // Store port and input ready
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = sfq_pkg::phys(head_reg, j_reg);
        mem_req.wdata = a_reg;
        mem_req.raddr = head_reg;
        case (state_reg)
            sfq_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            sfq_pkg::S_EXEC:
            begin
                if (op_reg == sfq_pkg::OP_ENQ && !full)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = sfq_pkg::phys(head_reg, count_reg);
                    mem_req.wdata = value_reg;
                end
            end
            sfq_pkg::S_SORT_LD:
            begin
                mem_req.raddr = sfq_pkg::phys(head_reg, i_reg);
            end
            sfq_pkg::S_SORT_AI, sfq_pkg::S_SORT_RDJ:
            begin
                mem_req.raddr = sfq_pkg::phys(head_reg, j_reg);
            end
            sfq_pkg::S_SORT_CMP:
            begin
                mem_req.we = swap;
            end
            sfq_pkg::S_SORT_WI:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sfq_pkg::phys(head_reg, i_reg);
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        op_next       = op_reg;
        value_next    = value_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        a_next        = a_reg;
        popped_next   = popped_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_popped_next = m_popped_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        case (state_reg)
            sfq_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next     = s_axis_tuser;
                    value_next  = s_axis_tdata[sfq_pkg::DATA_W-1:0];
                    popped_next = '0;
                    status_next = sfq_pkg::ST_OK;
                end
            end
            sfq_pkg::S_EXEC:
            begin
                i_next = '0;
                j_next = sfq_pkg::CNT_W'(1);
                case (op_reg)
                    sfq_pkg::OP_ENQ:
                    begin
                        if (full)
                            status_next = sfq_pkg::ST_FULL;
                        else
                            count_next = count_reg + 1'b1;
                    end
                    sfq_pkg::OP_DEQ:
                    begin
                        if (empty)
                            status_next = sfq_pkg::ST_EMPTY;
                    end
                    default:
                    begin
                        status_next = sfq_pkg::ST_OK;
                    end
                endcase
            end
            sfq_pkg::S_DEQ_RD:
            begin
                popped_next = rdata;
                count_next  = count_reg - 1'b1;
                if (count_reg == sfq_pkg::CNT_W'(1))
                    head_next = '0;
                else
                    head_next = sfq_pkg::phys(head_reg, sfq_pkg::CNT_W'(1));
            end
            sfq_pkg::S_SORT_AI:
            begin
                a_next = rdata;
            end
            sfq_pkg::S_SORT_CMP:
            begin
                if (swap)
                    a_next = rdata;
                if (j_more)
                    j_next = j_reg + 1'b1;
            end
            sfq_pkg::S_SORT_WI:
            begin
                i_next = i_reg + 1'b1;
                j_next = i_reg + 2'd2;
            end
            sfq_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_popped_next = popped_reg;
                    m_status_next = status_reg;
                    m_count_next  = count_reg;
                end
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sfq_pkg::S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        a_reg        <= a_next;
        popped_reg   <= popped_next;
        status_reg   <= status_next;
        m_popped_reg <= m_popped_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {{(sfq_pkg::M_TDATA_W - sfq_pkg::DATA_W - sfq_pkg::CNT_W){1'b0}},
                            m_count_reg, m_popped_reg};

    `SFQ_ASSERT_NOW(a_count_bound, 1'b1,
        count_reg <= sfq_pkg::CNT_W'(sfq_pkg::DEPTH), "count above depth")
    `SFQ_ASSERT_NEXT(a_xfer_exec, in_xfer,
        state_reg == sfq_pkg::S_EXEC, "transfer not executed")
    `SFQ_ASSERT_NEXT(a_sort_count, state_reg == sfq_pkg::S_SORT_CMP,
        $stable(count_reg), "sort changed count")
    `SFQ_ASSERT_NOW(a_full_count, m_axis_tvalid && m_axis_tuser == sfq_pkg::ST_FULL,
        m_count_reg == sfq_pkg::CNT_W'(sfq_pkg::DEPTH), "full status with room left")

endmodule

`default_nettype wire
